### design/lirs_pkg.sv
// lirs_pkg: shared types and constants for the linear interpolation resampler.
// No dependencies; linear_interp_resampler_unit, lirs_dp and lirs_ctrl import it.
`default_nettype none

package lirs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 18;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W = 1;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_FROM_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TO_RATE   = 1'd1;

  localparam logic [RATE_W-1:0] RESET_FROM_RATE = 18'd8000;
  localparam logic [RATE_W-1:0] RESET_TO_RATE   = 18'd48000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       in_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       out_last;
    logic                       out_empty;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // latch the incoming sample
    logic div_start;  // start the phase step division
    logic hold_put;   // release the held output
    logic mul;        // register the interpolation product
    logic emit;       // finish one interpolated output and advance phase
    logic put_s;      // emit current sample at end of chunk and advance phase
    logic flush;      // close out the item
  } lirs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic direct;     // item bypasses interpolation
    logic step_ok;    // phase step already computed
    logic div_busy;
    logic hold_hit;   // held output now falls inside the count
    logic l1_more;    // another output lies between previous and current sample
    logic l2_more;    // another output lies on the final sample
    logic in_count;   // next output number is inside the count
    logic pend_valid;
    logic item_last;
    logic out_free;   // output register can take a transfer this cycle
  } lirs_status_t;

endpackage

`default_nettype wire

### design/linear_interp_resampler_unit.sv
// Channel   Valid          Stall          Payload
// sample    sample_valid   sample_stall   sample_item (in_item_t)
// result    result_valid   result_stall   result_item (out_item_t)
// config    cfg_write      -              cfg_index, cfg_data
//
// Bypassed items go from IDLE straight to FLUSH. Other items pass through
// HOLD, NEXT and FLUSH, with MUL and EMIT for each interpolated output and
// TAIL for each output on the closing sample; the multiply is registered.
// The first interpolated item after reset or a config write also waits in DIV
// for the bit-serial phase step division (34 quotient bits).
// Reset is synchronous; rates return to 8000 and 48000 Hz.
// A stalled result holds only the output register: the next sample transfer
// is taken while it waits.
// Uses lirs_pkg, lirs_ctrl and lirs_dp.
`default_nettype none

module linear_interp_resampler_unit import lirs_pkg::*; #(
  parameter int COUNT_BITS   = 24,
  parameter int MAX_UPSAMPLE = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RATE_W-1:0]    cfg_data,
  input  wire logic                 sample_valid,
  output logic                      sample_stall,
  input  wire in_item_t             sample_item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output out_item_t                 result_item
);

  lirs_cmd_t    cmd;
  lirs_status_t st;

  lirs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .st           (st),
    .cmd          (cmd)
  );

  lirs_dp #(
    .COUNT_BITS   (COUNT_BITS),
    .MAX_UPSAMPLE (MAX_UPSAMPLE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_item  (sample_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

`default_nettype wire

### design/lirs_div.sv
// lirs_div: restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module lirs_div #(
  parameter int DIVIDEND_W = 34,
  parameter int DIVISOR_W  = 18
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       busy,
  output logic [DIVIDEND_W-1:0]      quotient,
  output logic [DIVISOR_W-1:0]       remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  acc;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    trial;
  logic                  take_bit;

  assign shifted  = {acc, quo[DIVIDEND_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign take_bit = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIVIDEND_W);
      acc  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      acc <= take_bit ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], take_bit};
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient  = quo;
  assign remainder = acc;

endmodule

`default_nettype wire

### design/lirs_dp.sv
// lirs_dp: rate registers, phase accumulator, interpolator, hold slot,
// pending result and output register. Uses lirs_pkg and lirs_div.
`default_nettype none

module lirs_dp import lirs_pkg::*; #(
  parameter int COUNT_BITS   = 24,
  parameter int MAX_UPSAMPLE = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RATE_W-1:0]    cfg_data,
  input  wire in_item_t             sample_item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output out_item_t                 result_item,
  input  wire lirs_cmd_t            cmd,
  output lirs_status_t              st
);

  localparam int CNT_W   = COUNT_BITS;
  localparam int NTO_W   = COUNT_BITS + RATE_W;
  localparam int LHS_W   = COUNT_BITS + RATE_W + 2;
  localparam int PHASE_W = ((COUNT_BITS > RATE_W) ? COUNT_BITS : RATE_W) + FRAC_W + 1;
  localparam int PIDX_W  = PHASE_W - FRAC_W;
  localparam int STEP_W  = RATE_W + FRAC_W;
  localparam int UPS_W   = RATE_W + $clog2(MAX_UPSAMPLE + 1);
  localparam int PROD_W  = 2 * (SAMPLE_W + 1);

  logic [RATE_W-1:0]          from_rate;
  logic [RATE_W-1:0]          to_rate;
  logic                       step_ok;
  logic signed [SAMPLE_W-1:0] prev;
  logic [CNT_W-1:0]           k;
  logic [NTO_W-1:0]           kt;      // k * to_rate
  logic [NTO_W-1:0]           nto;     // (k + 1) * to_rate for the item in work
  logic [LHS_W-1:0]           od_lhs;  // (outputs done + 1) * from_rate
  logic [PHASE_W-1:0]         phase;
  logic [RATE_W-1:0]          rem;
  logic                       hold_valid;
  logic signed [SAMPLE_W-1:0] hold_val;
  logic [LHS_W-1:0]           hold_lhs;
  logic signed [SAMPLE_W-1:0] cur_s;
  logic                       item_last;
  logic                       item_pt;
  logic signed [PROD_W-1:0]   prod;
  logic                       pend_valid;
  logic signed [SAMPLE_W-1:0] pend_val;

  logic                       div_busy;
  logic [STEP_W-1:0]          div_q;
  logic [RATE_W-1:0]          div_r;

  logic                       last_eff;
  logic                       pass;
  logic [UPS_W-1:0]           from_x;
  logic                       in_count;
  logic [CNT_W-1:0]           k_m1;
  logic [PIDX_W-1:0]          phase_idx;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W:0]   frac_s;
  logic signed [PROD_W-1:0]   prod_next;
  logic signed [PROD_W-1:0]   shifted;
  logic signed [PROD_W-1:0]   interp_sum;
  logic signed [SAMPLE_W-1:0] interp_val;
  logic [RATE_W:0]            rem_sum;
  logic [RATE_W:0]            rem_sub;
  logic                       wrap;
  logic [RATE_W-1:0]          rem_adv;
  logic [PHASE_W-1:0]         phase_adv;
  logic [LHS_W-1:0]           od_adv;
  logic                       advance;
  logic                       put_now;
  logic signed [SAMPLE_W-1:0] put_val;
  logic                       push_mid;
  logic                       push_flush;
  logic                       push;
  logic                       out_free;
  out_item_t                  push_item;

  lirs_div #(
    .DIVIDEND_W (STEP_W),
    .DIVISOR_W  (RATE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  ({from_rate, FRAC_W'(0)}),
    .divisor   (to_rate),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // bypass when a rate is zero, rates match, or the ratio is out of range
  assign from_x   = UPS_W'(from_rate) * UPS_W'(MAX_UPSAMPLE);
  assign pass     = (from_rate == '0) || (to_rate == '0) || (from_rate == to_rate) ||
                    (UPS_W'(to_rate) > from_x);
  assign last_eff = sample_item.in_last || (k == '1);

  assign in_count  = od_lhs <= LHS_W'(nto);
  assign k_m1      = k - CNT_W'(1);
  assign phase_idx = phase[PHASE_W-1:FRAC_W];

  // interpolation: prev + floor((cur - prev) * frac / 2^16)
  assign diff       = {cur_s[SAMPLE_W-1], cur_s} - {prev[SAMPLE_W-1], prev};
  assign frac_s     = $signed({1'b0, phase[FRAC_W-1:0]});
  assign prod_next  = diff * frac_s;
  assign shifted    = prod >>> FRAC_W;
  assign interp_sum = shifted + PROD_W'(prev);
  assign interp_val = interp_sum[SAMPLE_W-1:0];

  // phase step: whole part plus remainder modulo to_rate
  assign rem_sum   = {1'b0, rem} + {1'b0, div_r};
  assign wrap      = rem_sum >= {1'b0, to_rate};
  assign rem_sub   = rem_sum - {1'b0, to_rate};
  assign rem_adv   = wrap ? rem_sub[RATE_W-1:0] : rem_sum[RATE_W-1:0];
  assign phase_adv = phase + PHASE_W'(div_q) + PHASE_W'(wrap);
  assign od_adv    = od_lhs + LHS_W'(from_rate);
  assign advance   = cmd.emit | cmd.put_s;

  assign put_now = cmd.hold_put | (cmd.emit & in_count) | cmd.put_s;
  assign put_val = cmd.hold_put ? hold_val : (cmd.put_s ? cur_s : interp_val);

  // results wait one step in the pending slot so the final one can carry last
  assign push_mid   = put_now & pend_valid;
  assign push_flush = cmd.flush & (pend_valid | item_last);
  assign push       = push_mid | push_flush;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    push_item.out_sample = pend_val;
    push_item.out_last   = 1'b0;
    push_item.out_empty  = 1'b0;
    if (push_flush) begin
      push_item.out_sample = pend_valid ? pend_val : '0;
      push_item.out_last   = item_last;
      push_item.out_empty  = !pend_valid;
    end
  end

  assign st.direct     = pass || ((k == '0) && last_eff);
  assign st.step_ok    = step_ok;
  assign st.div_busy   = div_busy;
  assign st.hold_hit   = hold_valid && (hold_lhs <= LHS_W'(nto));
  assign st.l1_more    = (k != '0) && (phase_idx == PIDX_W'(k_m1));
  assign st.l2_more    = item_last && in_count && (phase_idx == PIDX_W'(k));
  assign st.in_count   = in_count;
  assign st.pend_valid = pend_valid;
  assign st.item_last  = item_last;
  assign st.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      from_rate  <= RESET_FROM_RATE;
      to_rate    <= RESET_TO_RATE;
      step_ok    <= 1'b0;
      prev       <= '0;
      k          <= '0;
      kt         <= '0;
      od_lhs     <= LHS_W'(RESET_FROM_RATE);
      phase      <= '0;
      rem        <= '0;
      hold_valid <= 1'b0;
      pend_valid <= 1'b0;
      item_last  <= 1'b0;
      item_pt    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FROM_RATE: from_rate <= cfg_data;
        REG_TO_RATE:   to_rate   <= cfg_data;
        default:       to_rate   <= to_rate;
      endcase
      step_ok    <= 1'b0;
      prev       <= '0;
      k          <= '0;
      kt         <= '0;
      od_lhs     <= LHS_W'((cfg_index == REG_FROM_RATE) ? cfg_data : from_rate);
      phase      <= '0;
      rem        <= '0;
      hold_valid <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        step_ok <= 1'b1;
      end
      if (cmd.take) begin
        cur_s     <= sample_item.in_sample;
        item_pt   <= pass;
        item_last <= pass ? sample_item.in_last : last_eff;
        nto       <= kt + NTO_W'(to_rate);
        if (st.direct) begin
          pend_val   <= sample_item.in_sample;
          pend_valid <= 1'b1;
        end
      end
      if (cmd.mul) begin
        prod <= prod_next;
      end
      if (cmd.hold_put) begin
        hold_valid <= 1'b0;
      end
      if (cmd.emit && !in_count && !item_last) begin
        hold_valid <= 1'b1;
        hold_val   <= interp_val;
        hold_lhs   <= od_lhs;
      end
      if (advance) begin
        phase  <= phase_adv;
        rem    <= rem_adv;
        od_lhs <= od_adv;
      end
      if (put_now) begin
        pend_val   <= put_val;
        pend_valid <= 1'b1;
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
        if (item_last) begin
          prev       <= '0;
          k          <= '0;
          kt         <= '0;
          od_lhs     <= LHS_W'(from_rate);
          phase      <= '0;
          rem        <= '0;
          hold_valid <= 1'b0;
        end else if (!item_pt) begin
          prev <= cur_s;
          k    <= k + CNT_W'(1);
          kt   <= nto;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push) begin
      result_valid <= 1'b1;
      result_item  <= push_item;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_release_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.hold_put |-> hold_valid)
    else $error("held output released while slot empty");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("output register overwritten before transfer");

  a_advance_after_div: assert property (@(posedge clk) disable iff (rst)
    advance |-> (step_ok && !div_busy))
    else $error("phase advanced without a finished step");
`endif

endmodule

`default_nettype wire

### design/lirs_ctrl.sv
// lirs_ctrl: per-item sequencer for the resampler datapath.
// Uses lirs_pkg command and status structs.
`default_nettype none

module lirs_ctrl import lirs_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         sample_valid,
  output logic              sample_stall,
  input  wire lirs_status_t st,
  output lirs_cmd_t         cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIV   = 8'b0000_0010,
    ST_HOLD  = 8'b0000_0100,
    ST_NEXT  = 8'b0000_1000,
    ST_MUL   = 8'b0001_0000,
    ST_EMIT  = 8'b0010_0000,
    ST_TAIL  = 8'b0100_0000,
    ST_FLUSH = 8'b1000_0000
  } state_t;

  state_t state_q;
  state_t state_next;
  logic   room;

  // a new result may enter the pending slot only if the old one can move out
  assign room         = !st.pend_valid || st.out_free;
  assign sample_stall = (state_q != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.take = 1'b1;
          if (st.direct) begin
            state_next = ST_FLUSH;
          end else if (!st.step_ok) begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_DIV: begin
        if (!st.div_busy) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!st.hold_hit) begin
          state_next = ST_NEXT;
        end else if (room) begin
          cmd.hold_put = 1'b1;
          state_next   = ST_NEXT;
        end
      end
      ST_NEXT: begin
        priority if (st.l1_more) begin
          state_next = ST_MUL;
        end else if (st.l2_more) begin
          state_next = ST_TAIL;
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!st.in_count || room) begin
          cmd.emit   = 1'b1;
          state_next = ST_NEXT;
        end
      end
      ST_TAIL: begin
        if (room) begin
          cmd.put_s  = 1'b1;
          state_next = ST_NEXT;
        end
      end
      ST_FLUSH: begin
        if (!(st.pend_valid || st.item_last) || st.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state_q == ST_IDLE && sample_valid) |=> (state_q != ST_IDLE))
    else $error("sample transfer did not start an item");

  a_take_pend_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !st.pend_valid)
    else $error("new item taken with a result still pending");
`endif

endmodule

`default_nettype wire
